// ===== rtl/core/stls_pkg.sv =====
// Shared types, constants and helpers for the symbol table lookup/store unit.
// Used by stls_ctrl, stls_dp and symbol_table_lookup_store_unit; no dependencies.
package stls_pkg;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned INDEX_W  = 6;

  // Request opcodes. The unused code behaves as a lookup.
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RECALL = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESULT
  } stls_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan;
    logic update;
  } stls_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic hit;
    logic miss_done;
  } stls_stat_t;

  // Keep bytes up to the first zero byte and at most max_chars of them.
  function automatic logic [KEY_W-1:0] norm_name(input logic [KEY_W-1:0] key,
                                                input int unsigned max_chars);
    logic [KEY_W-1:0] kept;
    logic             ended;
    kept  = '0;
    ended = 1'b0;
    for (int unsigned b = 0; b < 8; b++) begin
      if (b >= max_chars || key[8*b +: 8] == 8'h00) begin
        ended = 1'b1;
      end
      if (!ended) begin
        kept[8*b +: 8] = key[8*b +: 8];
      end
    end
    return kept;
  endfunction

endpackage

// ===== rtl/core/stls_ctrl.sv =====
// Controller state machine of the symbol table unit.
// Depends on stls_pkg for the state enum and the command/status structs.
module stls_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  input  stls_pkg::stls_stat_t  stat_i,
  output stls_pkg::stls_cmd_t   cmd_o,
  output logic                  busy,
  output logic                  done_o
);

  stls_pkg::stls_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= stls_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      stls_pkg::ST_IDLE: begin
        if (start) begin
          state_d = stls_pkg::ST_SCAN;
        end
      end
      stls_pkg::ST_SCAN: begin
        if (stat_i.hit || stat_i.miss_done) begin
          state_d = stls_pkg::ST_UPDATE;
        end
      end
      stls_pkg::ST_UPDATE: state_d = stls_pkg::ST_RESULT;
      stls_pkg::ST_RESULT: state_d = stls_pkg::ST_IDLE;
      default:             state_d = stls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.capture = (state_q == stls_pkg::ST_IDLE) && start;
    cmd_o.scan    = (state_q == stls_pkg::ST_SCAN);
    cmd_o.update  = (state_q == stls_pkg::ST_UPDATE);
    busy          = (state_q != stls_pkg::ST_IDLE);
    done_o        = (state_q == stls_pkg::ST_RESULT);
  end

endmodule

// ===== rtl/core/stls_dp.sv =====
// Datapath of the symbol table unit: name and value memories, scan counter, result registers.
// Depends on stls_pkg for widths, opcodes, the name normalizer and the command/status structs.
module stls_dp #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned NAME_CHARS    = 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  stls_pkg::stls_cmd_t                  cmd_i,
  output stls_pkg::stls_stat_t                 stat_o,
  input  logic [stls_pkg::OPCODE_W-1:0]        opcode_i,
  input  logic [stls_pkg::KEY_W-1:0]           name_key_i,
  input  logic [stls_pkg::VALUE_W-1:0]         write_value_i,
  output logic [stls_pkg::INDEX_W-1:0]         entry_index_o,
  output logic [stls_pkg::VALUE_W-1:0]         read_value_o,
  output logic                                 added_new_o,
  output logic                                 status_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

  logic [stls_pkg::KEY_W-1:0] name_mem  [TABLE_ENTRIES];
  logic [stls_pkg::VALUE_W-1:0] value_mem [TABLE_ENTRIES];

  logic [stls_pkg::OPCODE_W-1:0] op_q;
  logic [stls_pkg::KEY_W-1:0]    key_q;
  logic [stls_pkg::VALUE_W-1:0]  wval_q;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              scan_q, scan_d;
  logic                          pend_q, pend_d;
  logic [IDX_W-1:0]              pend_idx_q;
  logic [stls_pkg::KEY_W-1:0]    name_rdata_q;
  logic [stls_pkg::VALUE_W-1:0]  val_rdata_q;
  logic [IDX_W-1:0]              slot_q;
  logic                          added_q;
  logic                          full_q;

  logic                          issue_rd;
  logic                          is_store, is_recall;
  logic                          name_we, value_we, value_re;
  logic [stls_pkg::VALUE_W-1:0]  value_wdata;
  logic [IDX_W+stls_pkg::INDEX_W-1:0] slot_ext;

  assign is_store  = (op_q == stls_pkg::OP_STORE);
  assign is_recall = (op_q == stls_pkg::OP_RECALL);
  assign issue_rd  = cmd_i.scan && (scan_q < count_q);

  assign stat_o.hit       = pend_q && (name_rdata_q == key_q);
  assign stat_o.miss_done = !pend_q && (scan_q >= count_q);

  // A new entry always gets its value written, so filled slots never read stale data.
  assign name_we     = cmd_i.update && !full_q && added_q;
  assign value_we    = cmd_i.update && !full_q && (added_q || is_store);
  assign value_re    = cmd_i.update && !full_q && !added_q && is_recall;
  assign value_wdata = is_store ? wval_q : '0;

  always_comb begin
    scan_d  = scan_q;
    pend_d  = pend_q;
    count_d = count_q;
    if (cmd_i.capture) begin
      scan_d = '0;
      pend_d = 1'b0;
    end else if (cmd_i.scan) begin
      pend_d = issue_rd;
      if (issue_rd) begin
        scan_d = scan_q + CNT_W'(1);
      end
    end
    if (name_we) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      scan_q  <= '0;
      pend_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      scan_q  <= scan_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= opcode_i;
      key_q  <= stls_pkg::norm_name(name_key_i, NAME_CHARS);
      wval_q <= write_value_i;
    end
    if (issue_rd) begin
      pend_idx_q <= scan_q[IDX_W-1:0];
    end
    if (cmd_i.scan && stat_o.hit) begin
      slot_q  <= pend_idx_q;
      added_q <= 1'b0;
      full_q  <= 1'b0;
    end else if (cmd_i.scan && stat_o.miss_done) begin
      slot_q  <= count_q[IDX_W-1:0];
      added_q <= (count_q != FULL_COUNT);
      full_q  <= (count_q == FULL_COUNT);
    end
  end

  always_ff @(posedge clk_i) begin
    if (name_we) begin
      name_mem[slot_q] <= key_q;
    end
    if (issue_rd) begin
      name_rdata_q <= name_mem[scan_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (value_we) begin
      value_mem[slot_q] <= value_wdata;
    end
    if (value_re) begin
      val_rdata_q <= value_mem[slot_q];
    end
  end

  assign slot_ext      = {{stls_pkg::INDEX_W{1'b0}}, slot_q};
  assign entry_index_o = full_q ? '0 : slot_ext[stls_pkg::INDEX_W-1:0];
  assign read_value_o  = (!full_q && !added_q && is_recall) ? val_rdata_q : '0;
  assign added_new_o   = added_q;
  assign status_o      = full_q;

endmodule

// ===== rtl/core/symbol_table_lookup_store_unit.sv =====
// Top level of the symbol table lookup/store unit: controller plus datapath.
// Depends on stls_pkg, stls_ctrl and stls_dp.
//
//   Channel   Handshake                      Payload
//   request   start in, busy out             opcode_i, name_key_i, write_value_i
//   result    done_o strobe, one cycle       entry_index_o, read_value_o,
//                                             added_new_o, status_o
//
// A request is taken on a clock edge where start is high and busy is low.
// Each request yields exactly one result, shown for one cycle with done_o.
// The name memory is scanned one filled entry per cycle through its single
// registered read port, so the time a request takes grows with the number
// of filled entries, up to TABLE_ENTRIES.
// Reset clears the fill count and the controller; no clearing pass is needed
// because every new entry has its value written when it is appended.
// The receiver cannot stall results; busy stays high until the result is out.
module symbol_table_lookup_store_unit #(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned NAME_CHARS    = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [stls_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [stls_pkg::KEY_W-1:0]    name_key_i,
  input  logic [stls_pkg::VALUE_W-1:0]  write_value_i,
  output logic                          done_o,
  output logic [stls_pkg::INDEX_W-1:0]  entry_index_o,
  output logic [stls_pkg::VALUE_W-1:0]  read_value_o,
  output logic                          added_new_o,
  output logic                          status_o
);

  // Command and status groups between the controller and the datapath.
  stls_pkg::stls_cmd_t  cmd;
  stls_pkg::stls_stat_t stat;

  // The controller sequences capture, the scan over filled entries, the
  // memory update and the one-cycle result strobe.
  stls_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  // The datapath holds both memories, the fill count and the result registers.
  stls_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .NAME_CHARS    (NAME_CHARS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .opcode_i      (opcode_i),
    .name_key_i    (name_key_i),
    .write_value_i (write_value_i),
    .entry_index_o (entry_index_o),
    .read_value_o  (read_value_o),
    .added_new_o   (added_new_o),
    .status_o      (status_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for symbol_table_lookup_store_unit: lookup, store and recall
// requests against a behavioral prediction of the name table. Needs stls_pkg and the RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned NAME_CHARS    = 8;
  // Opcode 3 is not decoded by the block and must behave as a lookup.
  localparam logic [stls_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 500;
  localparam int NAME_POOL_SIZE  = 96;
  // A scan covers at most TABLE_ENTRIES filled slots; the rest is margin for request overhead.
  localparam int DRAIN_CYCLES = TABLE_ENTRIES + 20;
  // Allows about 600 requests, taken several times over.
  localparam int unsigned CYCLE_LIMIT = 300000;

  // One expected result, one field per result port.
  typedef struct packed {
    logic [stls_pkg::INDEX_W-1:0] entry_index;
    logic [stls_pkg::VALUE_W-1:0] read_value;
    logic                         added_new;
    logic                         status;
  } lookup_result_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni;
  logic                          start;
  logic                          busy;
  logic [stls_pkg::OPCODE_W-1:0] opcode_i;
  logic [stls_pkg::KEY_W-1:0]    name_key_i;
  logic [stls_pkg::VALUE_W-1:0]  write_value_i;
  logic                          done_o;
  logic [stls_pkg::INDEX_W-1:0]  entry_index_o;
  logic [stls_pkg::VALUE_W-1:0]  read_value_o;
  logic                          added_new_o;
  logic                          status_o;

  // Bench copy of the table. Only the first filled_slots names are ever compared.
  logic [stls_pkg::KEY_W-1:0]   name_slots  [TABLE_ENTRIES];
  logic [stls_pkg::VALUE_W-1:0] value_slots [TABLE_ENTRIES];
  int unsigned                  filled_slots;

  // Results predicted at request acceptance, oldest first.
  lookup_result_t pending_results [$];

  int unsigned error_count;
  int unsigned results_checked;
  int unsigned append_count;
  int unsigned hit_count;
  int unsigned refused_count;
  int unsigned cycle_count = 0;
  // When set, the sender raises start again right after each acceptance.
  logic        no_idle;

  symbol_table_lookup_store_unit #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .NAME_CHARS   (NAME_CHARS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .opcode_i     (opcode_i),
    .name_key_i   (name_key_i),
    .write_value_i(write_value_i),
    .done_o       (done_o),
    .entry_index_o(entry_index_o),
    .read_value_o (read_value_o),
    .added_new_o  (added_new_o),
    .status_o     (status_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // A name ends at its first zero byte or after NAME_CHARS bytes; the rest reads as zero.
  function automatic logic [stls_pkg::KEY_W-1:0] trim_name(
      input logic [stls_pkg::KEY_W-1:0] key);
    logic [stls_pkg::KEY_W-1:0] kept;
    kept = '0;
    for (int b = 0; b < NAME_CHARS; b++) begin
      if (key[8*b +: 8] == 8'h00) break;
      kept[8*b +: 8] = key[8*b +: 8];
    end
    return kept;
  endfunction

  // Searches the filled slots, appends on a miss, then applies the opcode.
  // Updates the bench table, so it is called once per accepted request.
  function automatic lookup_result_t resolve_name(
      input logic [stls_pkg::OPCODE_W-1:0] op,
      input logic [stls_pkg::KEY_W-1:0]    key,
      input logic [stls_pkg::VALUE_W-1:0]  val);
    lookup_result_t             res;
    logic [stls_pkg::KEY_W-1:0] name;
    int                         slot;
    res  = '0;
    slot = -1;
    name = trim_name(key);
    for (int i = 0; i < filled_slots; i++) begin
      if (name_slots[i] == name) begin
        slot = i;
        break;
      end
    end
    if (slot < 0) begin
      // Absent name on a full table: refused, and nothing changes, not even on a store.
      if (filled_slots >= TABLE_ENTRIES) begin
        res.status = 1'b1;
        refused_count++;
        return res;
      end
      slot = filled_slots;
      name_slots[slot] = name;
      filled_slots++;
      res.added_new = 1'b1;
      append_count++;
    end else begin
      hit_count++;
    end
    if (op == stls_pkg::OP_STORE) begin
      value_slots[slot] = val;
    end else if (op == stls_pkg::OP_RECALL) begin
      res.read_value = value_slots[slot];
    end
    res.entry_index = slot[stls_pkg::INDEX_W-1:0];
    return res;
  endfunction

  // Name of len nonzero characters, zero padded above.
  function automatic logic [stls_pkg::KEY_W-1:0] make_name(input int len);
    logic [stls_pkg::KEY_W-1:0] name;
    name = '0;
    for (int b = 0; b < len; b++) begin
      name[8*b +: 8] = 8'($urandom_range(1, 255));
    end
    return name;
  endfunction

  // Sometimes fills the bytes past the terminating zero with garbage, which must be ignored.
  function automatic logic [stls_pkg::KEY_W-1:0] add_junk(
      input logic [stls_pkg::KEY_W-1:0] name);
    logic [stls_pkg::KEY_W-1:0] noisy;
    int                         len;
    noisy = name;
    len   = 0;
    while (len < 8 && name[8*len +: 8] != 8'h00) len++;
    if (len < 7 && $urandom_range(0, 2) == 0) begin
      for (int b = len + 1; b < 8; b++) begin
        noisy[8*b +: 8] = 8'($urandom_range(0, 255));
      end
    end
    return noisy;
  endfunction

  task automatic report_mismatch(input string field,
                                 input logic [stls_pkg::VALUE_W-1:0] got,
                                 input logic [stls_pkg::VALUE_W-1:0] want);
    $display("ERROR result %0d at %0t ns: %s is %h, expected %h",
             results_checked, $time, field, got, want);
    error_count++;
  endtask

  // Sends one request. A random gap with start low comes first, unless no_idle is set;
  // start then stays high until an edge with busy low takes it.
  // Start is left high on return so that back-to-back requests need no extra edge.
  task automatic send_request(input logic [stls_pkg::OPCODE_W-1:0] op,
                              input logic [stls_pkg::KEY_W-1:0]    key,
                              input logic [stls_pkg::VALUE_W-1:0]  val);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    @(negedge clk_i);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         <= 1'b1;
    opcode_i      <= op;
    name_key_i    <= key;
    write_value_i <= val;
    do @(posedge clk_i); while (busy !== 1'b0);
    pending_results.push_back(resolve_name(op, key, val));
  endtask

  // Results are sampled at the rising edge that ends their strobe cycle.
  always @(posedge clk_i) begin : result_check
    lookup_result_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unrequested result, entry_index",
                        stls_pkg::VALUE_W'(entry_index_o), '0);
      end else begin
        want = pending_results.pop_front();
        if (entry_index_o !== want.entry_index)
          report_mismatch("entry_index", stls_pkg::VALUE_W'(entry_index_o),
                          stls_pkg::VALUE_W'(want.entry_index));
        if (read_value_o !== want.read_value)
          report_mismatch("read_value", read_value_o, want.read_value);
        if (added_new_o !== want.added_new)
          report_mismatch("added_new", stls_pkg::VALUE_W'(added_new_o),
                          stls_pkg::VALUE_W'(want.added_new));
        if (status_o !== want.status)
          report_mismatch("status", stls_pkg::VALUE_W'(status_o),
                          stls_pkg::VALUE_W'(want.status));
      end
      results_checked++;
    end
  end

  // A fresh name reads zero; stores and recalls of the value extremes round-trip.
  task automatic test_fresh_entry();
    send_request(stls_pkg::OP_LOOKUP, 64'h78, 64'hDEAD_BEEF_0000_0001);
    send_request(stls_pkg::OP_RECALL, 64'h78, '0);
    send_request(stls_pkg::OP_STORE,  64'h78, '1);
    send_request(stls_pkg::OP_RECALL, 64'h78, '0);
    send_request(stls_pkg::OP_STORE,  64'h78, '0);
    send_request(stls_pkg::OP_RECALL, 64'h78, '1);
  endtask

  // Empty name, bytes after the terminator, and a full eight-character name of 0xFF.
  task automatic test_name_forms();
    send_request(stls_pkg::OP_LOOKUP, 64'h0, '0);
    // Zero low byte: the rest is junk and this is the empty name again.
    send_request(stls_pkg::OP_RECALL, 64'hFFFF_FFFF_FFFF_FF00, '0);
    send_request(stls_pkg::OP_STORE,  '1, 64'h0123_4567_89AB_CDEF);
    send_request(stls_pkg::OP_RECALL, '1, '0);
    send_request(stls_pkg::OP_STORE,  64'h4241, 64'h8000_0000_0000_0000);
    // "AB" with garbage above its terminator must hit the same entry.
    send_request(stls_pkg::OP_RECALL, 64'h5A5A_A5A5_C300_4241, '0);
  endtask

  // The unused opcode looks up without writing, and appends on a miss like any opcode.
  task automatic test_opcodes();
    send_request(OP_UNUSED, 64'h78, 64'h1234_5678_9ABC_DEF0);
    send_request(stls_pkg::OP_RECALL, 64'h78, '0);
    send_request(OP_UNUSED, 64'h7A_79, '1);
    send_request(stls_pkg::OP_STORE,  64'h6F_6F_66, 64'h7FFF_FFFF_FFFF_FFFF);
    send_request(stls_pkg::OP_RECALL, 64'h6F_6F_66, '0);
  endtask

  // Mostly names from a fixed pool, so that hits, appends and (once the table
  // fills) refusals all occur; one request in eight carries an arbitrary key.
  task automatic test_random_traffic(input int count);
    logic [stls_pkg::KEY_W-1:0]    pool [NAME_POOL_SIZE];
    logic [stls_pkg::KEY_W-1:0]    key;
    logic [stls_pkg::VALUE_W-1:0]  val;
    logic [stls_pkg::OPCODE_W-1:0] op;
    for (int p = 0; p < NAME_POOL_SIZE; p++) begin
      pool[p] = make_name($urandom_range(1, 8));
    end
    for (int n = 0; n < count; n++) begin
      // Alternate stretches of back-to-back requests with stretches of random gaps.
      if (n % 60 == 0) no_idle = ($urandom_range(0, 2) == 0);
      op = stls_pkg::OPCODE_W'($urandom_range(0, 3));
      if ($urandom_range(0, 7) == 0) begin
        key = {$urandom, $urandom};
      end else begin
        key = add_junk(pool[$urandom_range(0, NAME_POOL_SIZE - 1)]);
      end
      case ($urandom_range(0, 5))
        0: begin
          val = '0;
        end
        1: begin
          val = '1;
        end
        default: begin
          val = {$urandom, $urandom};
        end
      endcase
      send_request(op, key, val);
    end
    no_idle = 1'b0;
  endtask

  // Tops the table up if needed, then checks that an absent name is refused
  // without any write, while stored names remain reachable.
  task automatic test_table_full();
    logic [stls_pkg::KEY_W-1:0] absent;
    logic [stls_pkg::KEY_W-1:0] last_name;
    last_name = '1;
    while (filled_slots < TABLE_ENTRIES) begin
      last_name = make_name(8);
      send_request(stls_pkg::OP_STORE, last_name, {$urandom, $urandom});
    end
    absent = make_name(8);
    send_request(stls_pkg::OP_STORE,  absent, '1);
    send_request(stls_pkg::OP_RECALL, absent, '0);
    send_request(stls_pkg::OP_LOOKUP, absent, '0);
    send_request(stls_pkg::OP_RECALL, last_name, '0);
    send_request(stls_pkg::OP_RECALL, 64'h0, '0);
  endtask

  initial begin
    // Every input is known from time zero; the value table starts cleared.
    rst_ni        = 1'b0;
    start         = 1'b0;
    opcode_i      = stls_pkg::OP_LOOKUP;
    name_key_i    = '0;
    write_value_i = '0;
    no_idle       = 1'b0;
    filled_slots  = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      value_slots[i] = '0;
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_fresh_entry();
    test_name_forms();
    test_opcodes();
    test_random_traffic(RANDOM_REQUESTS);
    test_table_full();

    @(negedge clk_i);
    start <= 1'b0;

    // Every result has to come back; then allow one more scan's worth of cycles
    // to catch a stray strobe.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d requests: %0d appended a name, %0d hit a stored name, %0d refused.",
             append_count + hit_count + refused_count, append_count, hit_count, refused_count);
    $display("All four opcodes, empty and padded names, value extremes and a full table ran.");
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d results outstanding",
             cycle_count, pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule
